FILE: hw/rtl/iau_pkg.sv
`default_nettype none
package iau_pkg;

    localparam int unsigned DataW = 32;

    typedef enum logic [5:0] {
        OP_ADD     = 6'h00, OP_AND    = 6'h01, OP_OR     = 6'h02, OP_XOR    = 6'h03,
        OP_SUB     = 6'h04, OP_ANDN   = 6'h05, OP_ORN    = 6'h06, OP_XNOR   = 6'h07,
        OP_ADDX    = 6'h08, OP_UMUL   = 6'h0A, OP_SMUL   = 6'h0B, OP_SUBX   = 6'h0C,
        OP_UDIV    = 6'h0E, OP_SDIV   = 6'h0F, OP_ADDCC  = 6'h10, OP_ANDCC  = 6'h11,
        OP_ORCC    = 6'h12, OP_XORCC  = 6'h13, OP_SUBCC  = 6'h14, OP_ANDNCC = 6'h15,
        OP_ORNCC   = 6'h16, OP_XNORCC = 6'h17, OP_ADDXCC = 6'h18, OP_UMULCC = 6'h1A,
        OP_SMULCC  = 6'h1B, OP_SUBXCC = 6'h1C, OP_UDIVCC = 6'h1E, OP_SDIVCC = 6'h1F,
        OP_TADDCC  = 6'h20, OP_TSUBCC = 6'h21, OP_TADDTV = 6'h22, OP_TSUBTV = 6'h23,
        OP_MULSCC  = 6'h24, OP_SLL    = 6'h25, OP_SRL    = 6'h26, OP_SRA    = 6'h27,
        OP_RDY     = 6'h28, OP_WRY    = 6'h30, OP_WRPSR  = 6'h31
    } t_op;

    typedef enum logic [1:0] {
        TRAP_NONE = 2'd0, TRAP_DIV0 = 2'd1, TRAP_TAG = 2'd2, TRAP_ILL = 2'd3
    } t_trap;

    localparam logic [3:0] FL_N = 4'b1000;
    localparam logic [3:0] FL_Z = 4'b0100;
    localparam logic [3:0] FL_V = 4'b0010;
    localparam logic [3:0] FL_C = 4'b0001;

    // Command from the sequencer to the shared add/subtract unit.
    typedef struct packed {
        logic [DataW-1:0] x;
        logic [DataW-1:0] y;
        logic             sub;
        logic             cin;
    } t_alu_cmd;

    typedef struct packed {
        logic [DataW-1:0] sum;
        logic             carry;
        logic             ovf;
    } t_alu_res;

endpackage
`default_nettype wire

FILE: hw/rtl/integer_alu_with_flags.sv
`default_nettype none
// Channel | Direction | Handshake            | Payload
// input   | in        | i_valid / o_ready    | i_func, i_a, i_b, i_asr_is_y
// output  | out       | o_valid / i_ready    | o_value, o_writes_dest, o_trap_code,
//         |           |                      | o_flags_out, o_y_out
//
// One transaction at a time runs through a sequencer around a single 32-bit
// adder/subtractor. Simple ops pass from the accept through S_EXEC to S_DONE,
// where the result is valid. Unsigned multiply takes 32 shift-add steps;
// signed multiply then applies a sign correction to the high word.
// Divide takes 1 overflow compare, 32 restoring steps and 1 sign fix;
// a divide by zero traps at simple-op speed. Reset clears the flags, Y, and all
// handshake state. A result waiting on a low i_ready holds the block; no new
// transaction is accepted until the result is taken.
module integer_alu_with_flags import iau_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  wire [5:0]  i_func,
    input  wire [31:0] i_a,
    input  wire [31:0] i_b,
    input  wire        i_asr_is_y,
    output logic       o_valid,
    input  wire        i_ready,
    output logic [31:0] o_value,
    output logic       o_writes_dest,
    output logic [1:0] o_trap_code,
    output logic [3:0] o_flags_out,
    output logic [31:0] o_y_out
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_EXEC = 7'b0000010, S_MUL  = 7'b0000100,
        S_MFIX = 7'b0001000, S_DIV  = 7'b0010000, S_DFIX = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic [5:0]  r_op;
    logic [31:0] r_a, r_b, r_acc, r_q, r_y, r_val;
    logic [3:0]  r_fl, r_fl_o;
    logic [31:0] r_y_o;
    logic        r_sel, r_wr;
    logic [1:0]  r_trap;
    logic [6:0]  r_cnt;
    logic        r_neg;      // signed divide: quotient negative
    logic        r_ovf;

    t_alu_cmd cmd;
    t_alu_res res;
    iau_addsub u_add (.i_cmd(cmd), .o_res(res));

    logic [31:0] mag_b;
    logic        is_div, is_mul, is_sgn;
    logic [31:0] sh_sra;

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_DONE);
    assign o_value = r_val;
    assign o_writes_dest = r_wr;
    assign o_trap_code = r_trap;
    assign o_flags_out = r_fl_o;
    assign o_y_out = r_y_o;

    always_comb begin
        is_mul = (r_op[3:1] == 3'b101) && !r_op[5];
        is_div = (r_op[3:1] == 3'b111) && !r_op[5];
        is_sgn = r_op[0];
        mag_b  = (is_sgn && r_b[31]) ? (32'd0 - r_b) : r_b;
        sh_sra = $signed(r_a) >>> r_b[4:0];
    end

    // Adder operand selection per state.
    always_comb begin
        cmd = '{x: r_a, y: r_b, sub: 1'b0, cin: 1'b0};
        unique case (r_state)
            S_EXEC: begin
                unique case (r_op)
                    OP_SUB, OP_SUBCC, OP_TSUBCC, OP_TSUBTV:
                        cmd = '{x: r_a, y: r_b, sub: 1'b1, cin: 1'b0};
                    OP_SUBX, OP_SUBXCC:
                        cmd = '{x: r_a, y: r_b, sub: 1'b1, cin: r_fl[0]};
                    OP_ADDX, OP_ADDXCC:
                        cmd = '{x: r_a, y: r_b, sub: 1'b0, cin: r_fl[0]};
                    OP_MULSCC:
                        cmd = '{x: {r_fl[3] ^ r_fl[1], r_a[31:1]},
                                y: r_y[0] ? r_b : 32'd0, sub: 1'b0, cin: 1'b0};
                    default: cmd = '{x: r_a, y: r_b, sub: 1'b0, cin: 1'b0};
                endcase
            end
            S_MUL:  cmd = '{x: r_acc, y: r_q[0] ? r_b : 32'd0, sub: 1'b0, cin: 1'b0};
            S_MFIX: cmd = '{x: r_acc, y: r_cnt[0] ? r_a : r_b, sub: 1'b1, cin: 1'b0};
            // The first divide cycle compares the dividend high half with the divisor.
            S_DIV:  cmd = '{x: (r_cnt == 7'd0) ? r_acc : {r_acc[30:0], r_q[31]},
                            y: mag_b, sub: 1'b1, cin: 1'b0};
            S_DFIX: cmd = '{x: 32'd0, y: r_q, sub: 1'b1, cin: 1'b0};
            default: cmd = '{x: r_a, y: r_b, sub: 1'b0, cin: 1'b0};
        endcase
    end

    function automatic logic [3:0] nz(input logic [31:0] v);
        return {v[31], v == 32'd0, 2'b00};
    endfunction

    logic [31:0] e_val;
    logic [3:0]  e_fl;
    logic [31:0] e_y;
    logic        e_wr;
    logic [1:0]  e_trap;
    logic [3:0]  add_fl;
    logic        tag_v;

    // Results and flags of the simple ops, computed in S_EXEC.
    always_comb begin
        add_fl = {res.sum[31], res.sum == 32'd0, res.ovf, res.carry};
        tag_v  = res.ovf || (r_a[1:0] != 2'b00) || (r_b[1:0] != 2'b00);
        e_val = res.sum; e_fl = r_fl; e_y = r_y; e_wr = 1'b1; e_trap = TRAP_NONE;
        unique case (r_op)
            OP_ADD, OP_SUB, OP_ADDX, OP_SUBX: ;
            OP_UMUL, OP_SMUL, OP_UMULCC, OP_SMULCC: ;
            OP_UDIV, OP_SDIV, OP_UDIVCC, OP_SDIVCC: begin
                if (r_b == 32'd0) e_trap = TRAP_DIV0;
            end
            OP_AND:  e_val = r_a & r_b;
            OP_OR:   e_val = r_a | r_b;
            OP_XOR:  e_val = r_a ^ r_b;
            OP_ANDN: e_val = r_a & ~r_b;
            OP_ORN:  e_val = r_a | ~r_b;
            OP_XNOR: e_val = ~(r_a ^ r_b);
            OP_ADDCC, OP_SUBCC, OP_ADDXCC, OP_SUBXCC: e_fl = add_fl;
            OP_ANDCC:  begin e_val = r_a & r_b;     e_fl = nz(e_val); end
            OP_ORCC:   begin e_val = r_a | r_b;     e_fl = nz(e_val); end
            OP_XORCC:  begin e_val = r_a ^ r_b;     e_fl = nz(e_val); end
            OP_ANDNCC: begin e_val = r_a & ~r_b;    e_fl = nz(e_val); end
            OP_ORNCC:  begin e_val = r_a | ~r_b;    e_fl = nz(e_val); end
            OP_XNORCC: begin e_val = ~(r_a ^ r_b);  e_fl = nz(e_val); end
            OP_TADDCC, OP_TSUBCC: e_fl = {add_fl[3:2], tag_v, add_fl[0]};
            OP_TADDTV, OP_TSUBTV: begin
                e_fl = {add_fl[3:2], 1'b0, add_fl[0]};
                if (tag_v) e_trap = TRAP_TAG;
            end
            OP_MULSCC: begin
                e_fl = add_fl;
                e_y  = {r_a[0], r_y[31:1]};
            end
            OP_SLL: e_val = r_a << r_b[4:0];
            OP_SRL: e_val = r_a >> r_b[4:0];
            OP_SRA: e_val = sh_sra;
            OP_RDY: e_val = r_sel ? r_y : 32'd0;
            OP_WRY: begin e_wr = 1'b0; if (r_sel) e_y = r_a ^ r_b; end
            OP_WRPSR: begin e_wr = 1'b0; e_fl = r_a[23:20] ^ r_b[23:20]; end
            default: e_trap = TRAP_ILL;
        endcase
        if (e_trap != TRAP_NONE) begin
            e_fl = r_fl; e_y = r_y; e_wr = 1'b0;
        end
        if (!e_wr) e_val = 32'd0;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid) n_state = S_EXEC;
            S_EXEC: begin
                if (is_mul) n_state = S_MUL;
                else if (is_div && r_b != 32'd0) n_state = S_DIV;
                else n_state = S_DONE;
            end
            S_MUL:  if (r_cnt == 7'd31) n_state = (is_sgn ? S_MFIX : S_DONE);
            S_MFIX: if (r_cnt[0]) n_state = S_DONE;
            S_DIV:  if (r_cnt == 7'd32) n_state = S_DFIX;
            S_DFIX: n_state = S_DONE;
            S_DONE: if (i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic [31:0] rem_sh;
    logic        fits;
    logic [31:0] qd;
    always_comb begin
        rem_sh = {r_acc[30:0], r_q[31]};
        fits   = r_acc[31] || !res.carry;
        qd     = r_q;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fl <= 4'd0; r_y <= 32'd0; r_fl_o <= 4'd0; r_y_o <= 32'd0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_op <= i_func; r_a <= i_a; r_b <= i_b; r_sel <= i_asr_is_y;
                end
                S_EXEC: begin
                    r_cnt <= 7'd0;
                    r_val <= e_val; r_wr <= e_wr; r_trap <= e_trap;
                    if (is_mul) begin
                        r_acc <= 32'd0; r_q <= r_a;
                    end else if (is_div && e_trap == TRAP_NONE) begin
                        // Magnitude of the 64-bit dividend Y:a.
                        if (is_sgn && r_y[31]) begin
                            {r_acc, r_q} <= 64'd0 - {r_y, r_a};
                        end else begin
                            {r_acc, r_q} <= {r_y, r_a};
                        end
                        r_neg <= is_sgn && (r_y[31] ^ r_b[31]);
                        r_ovf <= 1'b0;
                    end else begin
                        r_fl <= e_fl; r_y <= e_y; r_fl_o <= e_fl; r_y_o <= e_y;
                    end
                end
                S_MUL: begin
                    {r_acc, r_q} <= {res.carry, res.sum, r_q[31:1]};
                    r_cnt <= (r_cnt == 7'd31) ? 7'd0 : r_cnt + 7'd1;
                    if (r_cnt == 7'd31 && !is_sgn) begin
                        r_val <= {res.sum[0], r_q[31:1]};
                        r_y <= {res.carry, res.sum[31:1]};
                        r_y_o <= {res.carry, res.sum[31:1]};
                        if (r_op[4]) begin
                            r_fl <= nz({res.sum[0], r_q[31:1]});
                            r_fl_o <= nz({res.sum[0], r_q[31:1]});
                        end else r_fl_o <= r_fl;
                    end
                end
                S_MFIX: begin
                    // Signed correction: subtract b if a<0, then a if b<0.
                    if ((r_cnt[0] ? r_b[31] : r_a[31])) r_acc <= res.sum;
                    r_cnt <= r_cnt + 7'd1;
                    if (r_cnt[0]) begin
                        r_val <= r_q;
                        r_y <= r_b[31] ? res.sum : r_acc;
                        r_y_o <= r_b[31] ? res.sum : r_acc;
                        if (r_op[4]) begin
                            r_fl <= nz(r_q); r_fl_o <= nz(r_q);
                        end else r_fl_o <= r_fl;
                    end
                end
                S_DIV: begin
                    if (r_cnt == 7'd0) begin
                        // The quotient fits in 32 bits only when the high half of
                        // the dividend is below the divisor.
                        r_ovf <= !res.carry;
                    end else if (fits) begin
                        // Restoring step: 33-bit shifted remainder vs divisor.
                        r_acc <= res.sum;
                        r_q <= {r_q[30:0], 1'b1};
                    end else begin
                        r_acc <= rem_sh;
                        r_q <= {r_q[30:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 7'd1;
                end
                S_DFIX: begin
                    logic [31:0] q;
                    logic        ov;
                    q = qd; ov = r_ovf;
                    if (!is_sgn) begin
                        if (ov) q = 32'hFFFFFFFF;
                    end else if (r_neg) begin
                        if (ov || qd > 32'h80000000) begin q = 32'h80000000; ov = 1'b1; end
                        else q = res.sum;
                    end else begin
                        if (ov || qd[31]) begin q = 32'h7FFFFFFF; ov = 1'b1; end
                    end
                    r_val <= q;
                    r_y_o <= r_y;
                    if (r_op[4]) begin
                        r_fl <= nz(q) | (ov ? FL_V : 4'd0);
                        r_fl_o <= nz(q) | (ov ? FL_V : 4'd0);
                    end else r_fl_o <= r_fl;
                end
                default: ;
            endcase
        end
    end

    a_ready_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready and valid together");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid && $stable(o_value))
        else $error("result dropped");
    a_trap_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_trap_code != TRAP_NONE) |-> !o_writes_dest && o_value == 32'd0)
        else $error("trap wrote");
endmodule
`default_nettype wire

FILE: hw/rtl/iau_addsub.sv
`default_nettype none
module iau_addsub import iau_pkg::*; (
    input  wire t_alu_cmd i_cmd,
    output t_alu_res      o_res
);
    logic [DataW-1:0] yy;
    logic [DataW:0]   s;

    // Subtraction is x + ~y + !cin; carry is inverted back into a borrow.
    always_comb begin
        yy = i_cmd.sub ? ~i_cmd.y : i_cmd.y;
        s  = {1'b0, i_cmd.x} + {1'b0, yy} + {{DataW{1'b0}}, i_cmd.sub ^ i_cmd.cin};
        o_res.sum   = s[DataW-1:0];
        o_res.carry = s[DataW] ^ i_cmd.sub;
        o_res.ovf   = (i_cmd.x[DataW-1] == yy[DataW-1]) &&
                      (s[DataW-1] != i_cmd.x[DataW-1]);
    end
endmodule
`default_nettype wire

FILE: tb/tb_integer_alu_with_flags.sv
`timescale 1ns / 1ps
`default_nettype none

// Checks the integer execute unit: every accepted transaction is run through an
// in-bench model of the ALU, flags and Y register, and each returned result is
// compared field by field with the oldest expected result.
module tb_integer_alu_with_flags;
    import iau_pkg::*;

    // Stimulus item and expected result types.
    typedef struct packed {
        logic [5:0]  func;
        logic [31:0] a;
        logic [31:0] b;
        logic        sel_y;
    } t_op_item;

    typedef struct packed {
        logic [31:0] value;
        logic        wr;
        logic [1:0]  trap;
        logic [3:0]  flags;
        logic [31:0] y;
    } t_alu_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [5:0]  i_func;
    logic [31:0] i_a;
    logic [31:0] i_b;
    logic        i_asr_is_y;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_value;
    logic        o_writes_dest;
    logic [1:0]  o_trap_code;
    logic [3:0]  o_flags_out;
    logic [31:0] o_y_out;

    integer_alu_with_flags uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_func(i_func), .i_a(i_a), .i_b(i_b), .i_asr_is_y(i_asr_is_y),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_value(o_value), .o_writes_dest(o_writes_dest), .o_trap_code(o_trap_code),
        .o_flags_out(o_flags_out), .o_y_out(o_y_out)
    );

    // The clock runs at a 4 ns period.
    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // Pending stimulus, expected results, and the model's architectural state.
    t_op_item    pending_ops[$];
    t_alu_result expected_results[$];
    logic [3:0]  model_flags;
    logic [31:0] model_y;

    int unsigned sender_idle_pct;
    int unsigned receiver_idle_pct;
    bit          hold_sender;
    int unsigned error_count;
    int unsigned accepted_ops;
    int unsigned checked_results;
    int unsigned idle_cycles;
    int unsigned trap_hits[4];

    localparam int unsigned WatchdogLimit = 20000;

    function automatic logic [3:0] nz_bits(input logic [31:0] r);
        return {r[31], r == 32'd0, 2'b00};
    endfunction

    // Add with carry-in; returns the flags and the sum through res.
    function automatic logic [3:0] add_flags(input logic [31:0] x, input logic [31:0] y,
                                             input logic cin, output logic [31:0] res);
        logic [32:0] s;
        s = {1'b0, x} + {1'b0, y} + {32'd0, cin};
        res = s[31:0];
        return nz_bits(res) | {2'b00, (~(x[31] ^ y[31]) & (x[31] ^ res[31])), s[32]};
    endfunction

    // Subtract with borrow-in; C is the true borrow of the full operation.
    function automatic logic [3:0] sub_flags(input logic [31:0] x, input logic [31:0] y,
                                             input logic cin, output logic [31:0] res);
        logic [32:0] d;
        d = {1'b0, x} - {1'b0, y} - {32'd0, cin};
        res = d[31:0];
        return nz_bits(res) | {2'b00, ((x[31] ^ y[31]) & (x[31] ^ res[31])), d[32]};
    endfunction

    // Computes the result of one operation and advances the flags and Y.
    function automatic t_alu_result alu_predict(input t_op_item it);
        t_alu_result res;
        logic [31:0] r, y, o1, o2;
        logic [3:0]  f;
        logic [1:0]  trap;
        logic        wr, ovf, cin, dneg, vneg;
        logic [63:0] p, dend, dmag, vmag, q;
        r = 32'd0; f = model_flags; y = model_y; trap = TRAP_NONE; wr = 1'b1;
        cin = model_flags[0]; ovf = 1'b0;
        case (it.func)
            OP_ADD:   r = it.a + it.b;
            OP_AND:   r = it.a & it.b;
            OP_OR:    r = it.a | it.b;
            OP_XOR:   r = it.a ^ it.b;
            OP_SUB:   r = it.a - it.b;
            OP_ANDN:  r = it.a & ~it.b;
            OP_ORN:   r = it.a | ~it.b;
            OP_XNOR:  r = ~(it.a ^ it.b);
            OP_ADDX:  r = it.a + it.b + {31'd0, cin};
            OP_SUBX:  r = it.a - it.b - {31'd0, cin};
            OP_UMUL, OP_UMULCC: begin
                p = {32'd0, it.a} * {32'd0, it.b};
                y = p[63:32]; r = p[31:0];
                if (it.func == OP_UMULCC) f = nz_bits(r);
            end
            OP_SMUL, OP_SMULCC: begin
                p = $unsigned($signed({{32{it.a[31]}}, it.a}) * $signed({{32{it.b[31]}}, it.b}));
                y = p[63:32]; r = p[31:0];
                if (it.func == OP_SMULCC) f = nz_bits(r);
            end
            OP_UDIV, OP_UDIVCC, OP_SDIV, OP_SDIVCC: begin
                if (it.b == 32'd0) begin
                    trap = TRAP_DIV0;
                end else begin
                    dend = {model_y, it.a};
                    if (it.func[0]) begin
                        // Signed: divide magnitudes, then saturate by quotient sign.
                        dneg = model_y[31];
                        vneg = it.b[31];
                        dmag = dneg ? -dend : dend;
                        vmag = vneg ? {32'd0, -it.b} : {32'd0, it.b};
                        q = dmag / vmag;
                        if (dneg != vneg) begin
                            if (q > 64'h8000_0000) begin
                                q = 64'h8000_0000; ovf = 1'b1;
                            end
                            r = -q[31:0];
                        end else begin
                            if (q > 64'h7FFF_FFFF) begin
                                q = 64'h7FFF_FFFF; ovf = 1'b1;
                            end
                            r = q[31:0];
                        end
                    end else begin
                        q = dend / {32'd0, it.b};
                        if (q > 64'hFFFF_FFFF) begin
                            q = 64'hFFFF_FFFF; ovf = 1'b1;
                        end
                        r = q[31:0];
                    end
                    if (it.func[4]) f = nz_bits(r) | {2'b00, ovf, 1'b0};
                end
            end
            OP_ADDCC:  f = add_flags(it.a, it.b, 1'b0, r);
            OP_ANDCC:  begin r = it.a & it.b; f = nz_bits(r); end
            OP_ORCC:   begin r = it.a | it.b; f = nz_bits(r); end
            OP_XORCC:  begin r = it.a ^ it.b; f = nz_bits(r); end
            OP_SUBCC:  f = sub_flags(it.a, it.b, 1'b0, r);
            OP_ANDNCC: begin r = it.a & ~it.b; f = nz_bits(r); end
            OP_ORNCC:  begin r = it.a | ~it.b; f = nz_bits(r); end
            OP_XNORCC: begin r = ~(it.a ^ it.b); f = nz_bits(r); end
            OP_ADDXCC: f = add_flags(it.a, it.b, cin, r);
            OP_SUBXCC: f = sub_flags(it.a, it.b, cin, r);
            OP_TADDCC, OP_TSUBCC, OP_TADDTV, OP_TSUBTV: begin
                f = it.func[0] ? sub_flags(it.a, it.b, 1'b0, r)
                               : add_flags(it.a, it.b, 1'b0, r);
                // A nonzero tag in either operand counts as overflow.
                if ((it.a[1:0] | it.b[1:0]) != 2'b00) f[1] = 1'b1;
                if (it.func[1] && f[1]) trap = TRAP_TAG;
            end
            OP_MULSCC: begin
                o1 = {model_flags[3] ^ model_flags[1], it.a[31:1]};
                o2 = model_y[0] ? it.b : 32'd0;
                f = add_flags(o1, o2, 1'b0, r);
                y = {it.a[0], model_y[31:1]};
            end
            OP_SLL: r = it.a << it.b[4:0];
            OP_SRL: r = it.a >> it.b[4:0];
            OP_SRA: r = $unsigned($signed(it.a) >>> it.b[4:0]);
            OP_RDY: r = it.sel_y ? model_y : 32'd0;
            OP_WRY: begin
                if (it.sel_y) y = it.a ^ it.b;
                wr = 1'b0;
            end
            OP_WRPSR: begin
                o1 = it.a ^ it.b;
                f = o1[23:20];
                wr = 1'b0;
            end
            default: trap = TRAP_ILL;
        endcase
        // A trap leaves the architectural state untouched.
        if (trap != TRAP_NONE) begin
            wr = 1'b0; f = model_flags; y = model_y;
        end
        if (!wr) r = 32'd0;
        model_flags = f;
        model_y = y;
        res.value = r; res.wr = wr; res.trap = trap; res.flags = f; res.y = y;
        return res;
    endfunction

    // Driver: presents the next pending transaction, with random gaps. While the
    // sender is held, each transaction goes out only after every result has come.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            // The current transaction (if any) is accepted at this edge.
            if (pending_ops.size() != 0 &&
                (!hold_sender || (!i_valid && expected_results.size() == 0)) &&
                $urandom_range(99, 0) >= sender_idle_pct) begin
                t_op_item it;
                it = pending_ops.pop_front();
                i_valid    <= 1'b1;
                i_func     <= it.func;
                i_a        <= it.a;
                i_b        <= it.b;
                i_asr_is_y <= it.sel_y;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
        end
    end

    // Monitor: predicts on input acceptance, checks on output acceptance.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                t_op_item it;
                it = '{func: i_func, a: i_a, b: i_b, sel_y: i_asr_is_y};
                expected_results.push_back(alu_predict(it));
                accepted_ops++;
            end
            if (o_valid && i_ready) begin
                t_alu_result got, exp_r;
                got = '{value: o_value, wr: o_writes_dest, trap: o_trap_code,
                        flags: o_flags_out, y: o_y_out};
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    error_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    checked_results++;
                    trap_hits[got.trap]++;
                    if (got.value !== exp_r.value) begin
                        $display("%0t: value expected %h actual %h", $time, exp_r.value, got.value);
                        error_count++;
                    end
                    if (got.wr !== exp_r.wr) begin
                        $display("%0t: writes_dest expected %b actual %b", $time, exp_r.wr, got.wr);
                        error_count++;
                    end
                    if (got.trap !== exp_r.trap) begin
                        $display("%0t: trap expected %0d actual %0d", $time, exp_r.trap, got.trap);
                        error_count++;
                    end
                    if (got.flags !== exp_r.flags) begin
                        $display("%0t: flags expected %b actual %b", $time, exp_r.flags, got.flags);
                        error_count++;
                    end
                    if (got.y !== exp_r.y) begin
                        $display("%0t: y expected %h actual %h", $time, exp_r.y, got.y);
                        error_count++;
                    end
                end
            end
            // The watchdog counts cycles in which nothing is accepted.
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WatchdogLimit) begin
                $display("%0t: watchdog expired", $time);
                $display("[integer_alu_with_flags] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(7, 0))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'h7FFF_FFFF;
            4: return $urandom_range(15, 0);
            5: return {8'($urandom_range(255, 0)), 24'd0} | 32'($urandom_range(3, 0));
            default: return $urandom();
        endcase
    endfunction

    // Mostly legal op codes, with a share of unused ones.
    function automatic logic [5:0] rand_func();
        t_op op;
        int unsigned k;
        if ($urandom_range(9, 0) == 0) return 6'($urandom_range(63, 0));
        k = $urandom_range(op.num() - 1, 0);
        op = op.first();
        repeat (k) op = op.next();
        return op;
    endfunction

    task automatic queue_op(input logic [5:0] f, input logic [31:0] a, input logic [31:0] b,
                            input logic sel);
        pending_ops.push_back('{func: f, a: a, b: b, sel_y: sel});
    endtask

    task automatic queue_random(input int unsigned count);
        logic [5:0] f;
        for (int unsigned n = 0; n < count; n++) begin
            f = rand_func();
            // Loading Y first gives the multi-word divides a random high half.
            if ((f == OP_UDIV || f == OP_SDIV || f == OP_UDIVCC || f == OP_SDIVCC) &&
                $urandom_range(2, 0) == 0)
                queue_op(OP_WRY, rand_operand(), $urandom_range(3, 0) == 0 ? 32'd0 : rand_operand(),
                         1'b1);
            queue_op(f, rand_operand(), rand_operand(), 1'($urandom_range(1, 0)));
        end
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_valid || expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_ready = 1'b0;
        i_func = 6'd0; i_a = 32'd0; i_b = 32'd0; i_asr_is_y = 1'b0;
        model_flags = 4'd0; model_y = 32'd0;
        sender_idle_pct = 11; receiver_idle_pct = 86;
        hold_sender = 1'b0;
        error_count = 0; accepted_ops = 0; checked_results = 0; idle_cycles = 0;
        foreach (trap_hits[k]) trap_hits[k] = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: operand extremes, traps, Y paths and divide saturation.
        queue_op(OP_ADDCC,  32'hFFFF_FFFF, 32'd1, 1'b0);           // carry out, zero
        queue_op(OP_ADDXCC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);   // carry in and out
        queue_op(OP_SUBXCC, 32'd0, 32'hFFFF_FFFF, 1'b0);           // borrow with borrow in
        queue_op(OP_SUBCC,  32'h8000_0000, 32'd1, 1'b0);           // signed overflow
        queue_op(OP_TADDCC, 32'd1, 32'd4, 1'b0);                   // tag sets V
        queue_op(OP_TADDTV, 32'd4, 32'd3, 1'b0);                   // tag trap
        queue_op(OP_TSUBTV, 32'h8000_0000, 32'd4, 1'b0);           // overflow trap
        queue_op(OP_UDIV,   32'd5, 32'd0, 1'b0);                   // divide by zero
        queue_op(OP_SDIVCC, 32'd5, 32'd0, 1'b1);
        queue_op(6'h29,     32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);   // unused op
        queue_op(OP_WRY,    32'hFFFF_0000, 32'h0000_FFFF, 1'b1);   // Y = all ones
        queue_op(OP_UDIVCC, 32'd0, 32'd1, 1'b0);                   // unsigned saturation
        queue_op(OP_SDIVCC, 32'd0, 32'd1, 1'b0);                   // Y:a = -2^32
        queue_op(OP_WRY,    32'h0000_0001, 32'd0, 1'b1);
        queue_op(OP_SDIVCC, 32'd0, 32'hFFFF_FFFF, 1'b0);           // negative saturation
        queue_op(OP_SDIVCC, 32'd0, 32'd2, 1'b0);                   // positive saturation
        queue_op(OP_WRY,    32'h1234_5678, 32'd0, 1'b0);           // other ASR: ignored
        queue_op(OP_RDY,    32'd0, 32'd0, 1'b1);
        queue_op(OP_RDY,    32'd0, 32'd0, 1'b0);                   // other ASR reads zero
        queue_op(OP_SMULCC, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        queue_op(OP_MULSCC, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        queue_op(OP_WRPSR,  32'h00F0_0000, 32'h0050_0000, 1'b0);   // flags = 1010
        queue_op(OP_MULSCC, 32'h0000_0002, 32'hFFFF_FFFF, 1'b0);
        queue_op(OP_SRA,    32'h8000_0000, 32'd31, 1'b0);
        queue_op(OP_SLL,    32'hFFFF_FFFF, 32'hFFFF_FFE1, 1'b0);
        queue_random(550);
        wait_drained();

        // The sender waits for every expected result before each transaction.
        hold_sender = 1'b1;
        queue_random(50);
        wait_drained();
        @(posedge i_clk);
        hold_sender = 1'b0;

        sender_idle_pct = 86; receiver_idle_pct = 11;
        queue_random(500);
        wait_drained();

        sender_idle_pct = 0; receiver_idle_pct = 0;
        queue_random(600);
        wait_drained();
        repeat (100) @(posedge i_clk);

        $display("Covered %0d transactions, %0d results checked.", accepted_ops, checked_results);
        $display("Traps seen: div0 %0d, tag %0d, illegal op %0d.",
                 trap_hits[TRAP_DIV0], trap_hits[TRAP_TAG], trap_hits[TRAP_ILL]);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("[integer_alu_with_flags] OK");
        end else begin
            $display("[integer_alu_with_flags] ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
